// File: rtl/perpendicular_foot_point_unit_assert.svh
// Assertion macros used by the checker file.
// Both macros sample on the rising edge of clock.
`ifndef PERPENDICULAR_FOOT_POINT_UNIT_ASSERT_SVH
`define PERPENDICULAR_FOOT_POINT_UNIT_ASSERT_SVH
// Implication checked outside reset
`define PFP_ASSERT_IMPL(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, also checked across reset
`define PFP_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) (ante) |=> (cons)) else $error(msg);
`endif

// File: rtl/pfp_pkg.sv
// ----------------------------------------------------------------------------
// pfp_pkg
// Shared types for the perpendicular foot point unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package pfp_pkg;

   // Line classification reported with each result
   typedef enum logic [1:0] {
      CASE_GENERAL    = 2'd0,
      CASE_VERTICAL   = 2'd1,
      CASE_HORIZONTAL = 2'd2
   } line_case_type;

   // Side information that travels down the divider chain
   typedef struct packed {
      line_case_type kind;
      logic          neg_x;
      logic          neg_y;
   } pfp_tag_type;

endpackage

// File: rtl/pfp_if.sv
// ----------------------------------------------------------------------------
// pfp_req_if / pfp_rsp_if
// Valid/ready channels for the input points and the projected foot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface pfp_req_if #(parameter int CW = 16);
   logic          valid;
   logic          ready;
   logic [CW-1:0] line_a_x;
   logic [CW-1:0] line_a_y;
   logic [CW-1:0] line_b_x;
   logic [CW-1:0] line_b_y;
   logic [CW-1:0] point_x;
   logic [CW-1:0] point_y;
   modport source (output valid, line_a_x, line_a_y, line_b_x, line_b_y,
                   point_x, point_y, input ready);
   modport sink   (input valid, line_a_x, line_a_y, line_b_x, line_b_y,
                   point_x, point_y, output ready);
endinterface

interface pfp_rsp_if #(parameter int OW = 26);
   logic                  valid;
   logic                  ready;
   logic [OW-1:0]         foot_x;
   logic [OW-1:0]         foot_y;
   pfp_pkg::line_case_type line_case;
   modport source (output valid, foot_x, foot_y, line_case, input ready);
   modport sink   (input valid, foot_x, foot_y, line_case, output ready);
endinterface

// File: rtl/perpendicular_foot_point_unit.sv
// ----------------------------------------------------------------------------
// perpendicular_foot_point_unit
// Foot of the perpendicular from a point onto a line through two points.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one transaction per problem: line points A, B and point P as
//   signed integers. rsp returns foot_x, foot_y as signed fixed point with
//   FRAC_BITS fraction bits, rounded to nearest (ties away from zero), and
//   line_case (general, vertical, horizontal).
//   Throughput: one transaction per clock, sustained while rsp.ready is high.
//   Path from request acceptance to response valid: four front stages,
//   one divider cell per quotient bit, and the rounding output register.
//   The quotient chain has one cell per result bit, each passing its partial
//   remainder to the next cell whenever that cell can accept it.
//   Reset empties every stage; rsp.valid drops in the next cycle.
//   When rsp.ready is low, each stage still fills any empty stage ahead of
//   it, so requests are taken until the whole chain is occupied.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module perpendicular_foot_point_unit #(
   parameter int COORD_WIDTH = 16,
   parameter int FRAC_BITS   = 8
) (
   input logic      clock,
   input logic      reset,
   pfp_req_if.sink  req,
   pfp_rsp_if.source rsp
);
   import pfp_pkg::*;

   localparam int DW   = COORD_WIDTH + 1;
   localparam int DENW = 2 * DW;
   localparam int RW   = DENW + 1;
   localparam int QW   = COORD_WIDTH + 2 + FRAC_BITS;
   localparam logic [QW-1:0] POS_MAX = {1'b0, {(QW-1){1'b1}}};
   localparam logic [QW-1:0] NEG_MAX = {1'b1, {(QW-1){1'b0}}};

   // chain links, index 0 is the front end output
   logic              c_valid [0:QW];
   logic              c_ready [0:QW];
   pfp_tag_type       c_tag   [0:QW];
   logic [DENW-1:0]   c_d     [0:QW];
   logic [RW-1:0]     c_rx    [0:QW];
   logic [QW-1:0]     c_bx    [0:QW];
   logic [RW-1:0]     c_ry    [0:QW];
   logic [QW-1:0]     c_by    [0:QW];

   pfp_front #(.CW(COORD_WIDTH), .F(FRAC_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req.valid),
      .in_ready   (req.ready),
      .ax         ($signed(req.line_a_x)),
      .ay         ($signed(req.line_a_y)),
      .bx         ($signed(req.line_b_x)),
      .by         ($signed(req.line_b_y)),
      .px         ($signed(req.point_x)),
      .py         ($signed(req.point_y)),
      .out_valid  (c_valid[0]),
      .out_ready  (c_ready[0]),
      .out_tag    (c_tag[0]),
      .out_d      (c_d[0]),
      .out_rem_x  (c_rx[0]),
      .out_bits_x (c_bx[0]),
      .out_rem_y  (c_ry[0]),
      .out_bits_y (c_by[0])
   );

   // one cell per quotient bit, most significant first
   for (genvar i = 0; i < QW; i++) begin : g_cell
      pfp_div_cell #(.RW(RW), .QW(QW), .DENW(DENW)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .in_valid   (c_valid[i]),
         .in_ready   (c_ready[i]),
         .in_tag     (c_tag[i]),
         .in_d       (c_d[i]),
         .in_rem_x   (c_rx[i]),
         .in_bits_x  (c_bx[i]),
         .in_rem_y   (c_ry[i]),
         .in_bits_y  (c_by[i]),
         .out_valid  (c_valid[i+1]),
         .out_ready  (c_ready[i+1]),
         .out_tag    (c_tag[i+1]),
         .out_d      (c_d[i+1]),
         .out_rem_x  (c_rx[i+1]),
         .out_bits_x (c_bx[i+1]),
         .out_rem_y  (c_ry[i+1]),
         .out_bits_y (c_by[i+1])
      );
   end

   // output register: round half away from zero, apply sign, saturate
   logic              ov_ff;
   logic [QW-1:0]     fx_ff, fy_ff, fx_in, fy_in;
   line_case_type     lc_ff;
   logic [RW:0]       dext;
   logic              rnd_x, rnd_y;
   logic [QW:0]       qx, qy;
   logic [QW-1:0]     cx, cy;

   assign c_ready[QW] = !ov_ff || rsp.ready;

   always_comb begin
      dext  = (RW+1)'(c_d[QW]);
      rnd_x = {c_rx[QW], 1'b0} >= dext;
      rnd_y = {c_ry[QW], 1'b0} >= dext;
      qx    = (QW+1)'(c_bx[QW]) + (QW+1)'(rnd_x);
      qy    = (QW+1)'(c_by[QW]) + (QW+1)'(rnd_y);
      if (c_tag[QW].neg_x) cx = (qx > (QW+1)'(NEG_MAX)) ? NEG_MAX : QW'(qx);
      else cx = (qx > (QW+1)'(POS_MAX)) ? POS_MAX : QW'(qx);
      if (c_tag[QW].neg_y) cy = (qy > (QW+1)'(NEG_MAX)) ? NEG_MAX : QW'(qy);
      else cy = (qy > (QW+1)'(POS_MAX)) ? POS_MAX : QW'(qy);
      fx_in = c_tag[QW].neg_x ? QW'(-cx) : cx;
      fy_in = c_tag[QW].neg_y ? QW'(-cy) : cy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (c_ready[QW]) begin
         ov_ff <= c_valid[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (c_ready[QW]) begin
         fx_ff <= fx_in;
         fy_ff <= fy_in;
         lc_ff <= c_tag[QW].kind;
      end
   end

   assign rsp.valid     = ov_ff;
   assign rsp.foot_x    = fx_ff;
   assign rsp.foot_y    = fy_ff;
   assign rsp.line_case = lc_ff;
endmodule

// File: rtl/pfp_front.sv
// ----------------------------------------------------------------------------
// pfp_front
// Four-stage front end: differences, dot product and norm, products, and
// the signed numerator split into divider remainder and dividend bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module pfp_front #(
   parameter int CW = 16,
   parameter int F  = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [CW-1:0]          ax,
   input  logic signed [CW-1:0]          ay,
   input  logic signed [CW-1:0]          bx,
   input  logic signed [CW-1:0]          by,
   input  logic signed [CW-1:0]          px,
   input  logic signed [CW-1:0]          py,
   output logic                          out_valid,
   input  logic                          out_ready,
   output pfp_pkg::pfp_tag_type          out_tag,
   output logic [2*CW+1:0]               out_d,
   output logic [2*CW+2:0]               out_rem_x,
   output logic [CW+1+F:0]               out_bits_x,
   output logic [2*CW+2:0]               out_rem_y,
   output logic [CW+1+F:0]               out_bits_y
);
   import pfp_pkg::*;

   localparam int DW   = CW + 1;
   localparam int NW   = 2 * DW + 1;
   localparam int DENW = 2 * DW;
   localparam int SW   = 3 * DW + 2;
   localparam int QW   = CW + 2 + F;
   localparam int VW   = SW + F;

   // stage handshake
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic r1, r2, r3, r4;
   assign r4       = !v4_ff || out_ready;
   assign r3       = !v3_ff || r4;
   assign r2       = !v2_ff || r3;
   assign r1       = !v1_ff || r2;
   assign in_ready = r1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (r1) v1_ff <= in_valid;
         if (r2) v2_ff <= v1_ff;
         if (r3) v3_ff <= v2_ff;
         if (r4) v4_ff <= v3_ff;
      end
   end

   // stage 1: differences and line classification
   logic signed [DW-1:0] dx1_ff, dy1_ff, ex1_ff, ey1_ff;
   logic signed [DW-1:0] dx1_in, dy1_in, ex1_in, ey1_in;
   logic signed [CW-1:0] ax1_ff, ay1_ff, sx1_ff, sy1_ff, sx1_in, sy1_in;
   line_case_type        kind1_ff, kind1_in;

   always_comb begin
      dx1_in = DW'(bx) - DW'(ax);
      dy1_in = DW'(by) - DW'(ay);
      ex1_in = DW'(px) - DW'(ax);
      ey1_in = DW'(py) - DW'(ay);
      if (bx == ax) begin
         kind1_in = CASE_VERTICAL;
         sx1_in   = ax;
         sy1_in   = py;
      end else if (by == ay) begin
         kind1_in = CASE_HORIZONTAL;
         sx1_in   = px;
         sy1_in   = ay;
      end else begin
         kind1_in = CASE_GENERAL;
         sx1_in   = ax;
         sy1_in   = ay;
      end
   end

   always_ff @(posedge clock) begin
      if (r1) begin
         dx1_ff   <= dx1_in;
         dy1_ff   <= dy1_in;
         ex1_ff   <= ex1_in;
         ey1_ff   <= ey1_in;
         ax1_ff   <= ax;
         ay1_ff   <= ay;
         sx1_ff   <= sx1_in;
         sy1_ff   <= sy1_in;
         kind1_ff <= kind1_in;
      end
   end

   // stage 2: dot product and squared length; special lines divide by one
   logic signed [2*DW-1:0] pex, pey, pdx, pdy;
   logic signed [NW-1:0]   n2_ff, n2_in;
   logic [DENW-1:0]        d2_ff, d2_in;
   logic signed [DW-1:0]   dx2_ff, dy2_ff;
   logic signed [CW-1:0]   ax2_ff, ay2_ff, sx2_ff, sy2_ff;
   line_case_type          kind2_ff;

   always_comb begin
      pex   = ex1_ff * dx1_ff;
      pey   = ey1_ff * dy1_ff;
      pdx   = dx1_ff * dx1_ff;
      pdy   = dy1_ff * dy1_ff;
      n2_in = NW'(pex) + NW'(pey);
      if (kind1_ff == CASE_GENERAL) d2_in = DENW'(pdx) + DENW'(pdy);
      else d2_in = DENW'(1);
   end

   always_ff @(posedge clock) begin
      if (r2) begin
         n2_ff    <= n2_in;
         d2_ff    <= d2_in;
         dx2_ff   <= dx1_ff;
         dy2_ff   <= dy1_ff;
         ax2_ff   <= ax1_ff;
         ay2_ff   <= ay1_ff;
         sx2_ff   <= sx1_ff;
         sy2_ff   <= sy1_ff;
         kind2_ff <= kind1_ff;
      end
   end

   // stage 3: base * norm and dot * delta per axis
   logic signed [CW+DENW:0]   mx3_ff, my3_ff;
   logic signed [NW+DW-1:0]   nx3_ff, ny3_ff;
   logic [DENW-1:0]           d3_ff;
   logic signed [CW-1:0]      sx3_ff, sy3_ff;
   line_case_type             kind3_ff;

   always_ff @(posedge clock) begin
      if (r3) begin
         mx3_ff   <= ax2_ff * $signed({1'b0, d2_ff});
         my3_ff   <= ay2_ff * $signed({1'b0, d2_ff});
         nx3_ff   <= n2_ff * dx2_ff;
         ny3_ff   <= n2_ff * dy2_ff;
         d3_ff    <= d2_ff;
         sx3_ff   <= sx2_ff;
         sy3_ff   <= sy2_ff;
         kind3_ff <= kind2_ff;
      end
   end

   // stage 4: numerator sum, magnitude, scale by fraction bits
   logic signed [SW-1:0] sum_x, sum_y;
   logic [SW-1:0]        mag_x, mag_y;
   logic [VW-1:0]        v_x, v_y;
   pfp_tag_type          tag4_ff, tag4_in;
   logic [DENW-1:0]      d4_ff;
   logic [VW-QW-1:0]     rx4_ff, ry4_ff;
   logic [QW-1:0]        bx4_ff, by4_ff;

   always_comb begin
      if (kind3_ff == CASE_GENERAL) begin
         sum_x = SW'(mx3_ff) + SW'(nx3_ff);
         sum_y = SW'(my3_ff) + SW'(ny3_ff);
      end else begin
         sum_x = SW'(sx3_ff);
         sum_y = SW'(sy3_ff);
      end
      mag_x         = sum_x[SW-1] ? SW'(-sum_x) : SW'(sum_x);
      mag_y         = sum_y[SW-1] ? SW'(-sum_y) : SW'(sum_y);
      v_x           = VW'(mag_x) << F;
      v_y           = VW'(mag_y) << F;
      tag4_in.kind  = kind3_ff;
      tag4_in.neg_x = sum_x[SW-1];
      tag4_in.neg_y = sum_y[SW-1];
   end

   always_ff @(posedge clock) begin
      if (r4) begin
         tag4_ff <= tag4_in;
         d4_ff   <= d3_ff;
         rx4_ff  <= v_x[VW-1:QW];
         ry4_ff  <= v_y[VW-1:QW];
         bx4_ff  <= v_x[QW-1:0];
         by4_ff  <= v_y[QW-1:0];
      end
   end

   assign out_valid  = v4_ff;
   assign out_tag    = tag4_ff;
   assign out_d      = d4_ff;
   assign out_rem_x  = rx4_ff;
   assign out_rem_y  = ry4_ff;
   assign out_bits_x = bx4_ff;
   assign out_bits_y = by4_ff;
endmodule

// File: rtl/pfp_div_cell.sv
// ----------------------------------------------------------------------------
// pfp_div_cell
// One restoring division step for both axes; resolves one quotient bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module pfp_div_cell #(
   parameter int RW   = 35,
   parameter int QW   = 26,
   parameter int DENW = 34
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  pfp_pkg::pfp_tag_type in_tag,
   input  logic [DENW-1:0]      in_d,
   input  logic [RW-1:0]        in_rem_x,
   input  logic [QW-1:0]        in_bits_x,
   input  logic [RW-1:0]        in_rem_y,
   input  logic [QW-1:0]        in_bits_y,
   output logic                 out_valid,
   input  logic                 out_ready,
   output pfp_pkg::pfp_tag_type out_tag,
   output logic [DENW-1:0]      out_d,
   output logic [RW-1:0]        out_rem_x,
   output logic [QW-1:0]        out_bits_x,
   output logic [RW-1:0]        out_rem_y,
   output logic [QW-1:0]        out_bits_y
);
   import pfp_pkg::*;

   logic              v_ff;
   pfp_tag_type       tag_ff;
   logic [DENW-1:0]   d_ff;
   logic [RW-1:0]     rx_ff, ry_ff, rx_in, ry_in;
   logic [QW-1:0]     bx_ff, by_ff, bx_in, by_in;
   logic [RW:0]       tx, ty, dext;
   logic              gx, gy;

   assign in_ready = !v_ff || out_ready;

   // shift in next dividend bit, trial subtract, shift out quotient bit
   always_comb begin
      dext  = (RW+1)'(in_d);
      tx    = {in_rem_x, in_bits_x[QW-1]};
      ty    = {in_rem_y, in_bits_y[QW-1]};
      gx    = tx >= dext;
      gy    = ty >= dext;
      rx_in = gx ? RW'(tx - dext) : RW'(tx);
      ry_in = gy ? RW'(ty - dext) : RW'(ty);
      bx_in = {in_bits_x[QW-2:0], gx};
      by_in = {in_bits_y[QW-2:0], gy};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (in_ready) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         tag_ff <= in_tag;
         d_ff   <= in_d;
         rx_ff  <= rx_in;
         ry_ff  <= ry_in;
         bx_ff  <= bx_in;
         by_ff  <= by_in;
      end
   end

   assign out_valid  = v_ff;
   assign out_tag    = tag_ff;
   assign out_d      = d_ff;
   assign out_rem_x  = rx_ff;
   assign out_rem_y  = ry_ff;
   assign out_bits_x = bx_ff;
   assign out_bits_y = by_ff;
endmodule

// File: rtl/pfp_checker.sv
// ----------------------------------------------------------------------------
// pfp_checker
// Port-level checks on the response channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "perpendicular_foot_point_unit_assert.svh"
module pfp_checker #(
   parameter int FRAC_BITS = 8,
   parameter int OW        = 26
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [OW-1:0]          foot_x,
   input logic [OW-1:0]          foot_y,
   input pfp_pkg::line_case_type line_case
);
   import pfp_pkg::*;

   logic [OW-1:0] frac_mask;
   assign frac_mask = (OW'(1) << FRAC_BITS) - OW'(1);

   // response channel empty after reset
   `PFP_ASSERT_NEXT(a_rst_empty, reset, !rsp_valid, "rsp valid right after reset")
   // stalled transaction is held
   `PFP_ASSERT_IMPL(a_hold, $past(rsp_valid && !rsp_ready && !reset), rsp_valid && $stable(foot_x) && $stable(foot_y), "stalled response changed")
   // axis-aligned lines give whole coordinates
   `PFP_ASSERT_IMPL(a_vert_int, rsp_valid && line_case == CASE_VERTICAL, (foot_x & frac_mask) == '0 && (foot_y & frac_mask) == '0, "vertical foot not integral")
   `PFP_ASSERT_IMPL(a_horz_int, rsp_valid && line_case == CASE_HORIZONTAL, (foot_x & frac_mask) == '0 && (foot_y & frac_mask) == '0, "horizontal foot not integral")
endmodule

bind perpendicular_foot_point_unit pfp_checker #(
   .FRAC_BITS (FRAC_BITS),
   .OW        (COORD_WIDTH + 2 + FRAC_BITS)
) u_pfp_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .foot_x    (rsp.foot_x),
   .foot_y    (rsp.foot_y),
   .line_case (rsp.line_case)
);
